/* sv/bbd_pkg.sv */
// Shared types, constants and helpers for the Bayer bilinear demosaic.
// Used by the interpolator and the top level.
package bbd_pkg;

	localparam int MAX_WIDTH_DEF = 256;

	localparam int CFG_DW = 12;
	localparam logic [8:0]  IMG_W_RESET = 9'd160;
	localparam logic [11:0] IMG_H_RESET = 12'd120;
	localparam logic [8:0]  WIDTH_MIN   = 9'd3;
	localparam logic [11:0] HEIGHT_MIN  = 12'd3;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// item queue between the window stage and the pixel serializer
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// floor(x / 3) == (x * 683) >> 11 for every x below 2048
	localparam int RECIP3_SHIFT = 11;
	localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 11'd683;

	typedef struct packed {
		logic [7:0] raw_sample;
		logic       frame_start;
	} bbd_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_of_run;
		logic       frame_end;
	} bbd_out_t;

	typedef struct packed {
		logic              index;
		logic [CFG_DW-1:0] wdata;
	} bbd_cfg_t;

	// One accepted sample: the 3x3 window after the shift plus what the
	// serializer needs to build the up to four pixels it releases.
	typedef struct packed {
		logic [8:0][7:0] win;
		logic            col_odd;
		logic            row_odd;
		logic            col_ge2;
		logic            row_ge2;
		logic [3:0]      flags;
	} bbd_item_t;

	// One output pixel: neighborhood centered on it and its in-frame borders.
	typedef struct packed {
		logic [8:0][7:0] nb;
		logic            left_ok;
		logic            right_ok;
		logic            top_ok;
		logic            bottom_ok;
		logic            px_odd;
		logic            py_odd;
		logic            last;
		logic            frame_end;
	} bbd_job_t;

	function automatic logic [7:0] div_mean(input logic [9:0] num, input logic [2:0] cnt);
		logic [RECIP3_SHIFT+9:0] prod;
		logic [7:0]              res;
		prod = (RECIP3_SHIFT+10)'(num) * (RECIP3_SHIFT+10)'(RECIP3);
		unique case (cnt)
			3'd1: res = num[7:0];
			3'd2: res = num[8:1];
			3'd3: res = prod[RECIP3_SHIFT +: 8];
			3'd4: res = num[9:2];
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

/* sv/bbd_stream_if.sv */
// Valid/ready channel with a typed payload.
// Payload types come from bbd_pkg.
interface bbd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/bbd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// A read at the address written in the same cycle returns the old contents.
module bbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/bbd_interp.sv */
// Two-stage bilinear interpolator: masked neighborhood sums, then the means.
// Depends on bbd_pkg (job and output types, div_mean) and bbd_stream_if.
module bbd_interp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  bbd_pkg::bbd_job_t job,
	output logic              job_ready,
	bbd_stream_if.source      pix_out
);

	typedef enum logic [1:0] {OWN_RED, OWN_GREEN_R, OWN_GREEN_B, OWN_BLUE} own_t;

	logic [2:0]      col_ok, row_ok;
	logic [8:0]      in_frame;
	logic [8:0][7:0] tm;
	logic [9:0]      d_sum, h_sum, v_sum, o_sum;
	logic [2:0]      d_cnt, h_cnt, v_cnt, o_cnt;
	own_t            own;
	logic [9:0]      num_r, num_g, num_b;
	logic [2:0]      cnt_r, cnt_g, cnt_b;

	own_t       own_s3;
	logic [7:0] centre_s3;
	logic [9:0] num_r_s3, num_g_s3, num_b_s3;
	logic [2:0] cnt_r_s3, cnt_g_s3, cnt_b_s3;
	logic       last_s3, fe_s3, valid_s3;

	bbd_pkg::bbd_out_t out_s4;
	logic              valid_s4;

	assign job_ready = !valid_s4 || pix_out.ready;

	assign col_ok = {job.right_ok, 1'b1, job.left_ok};
	assign row_ok = {job.bottom_ok, 1'b1, job.top_ok};

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				in_frame[4'(j*3+k)] = row_ok[j] && col_ok[k];
				tm[4'(j*3+k)] = (row_ok[j] && col_ok[k]) ? job.nb[4'(j*3+k)] : '0;
			end
		end
	end

	// diagonal, horizontal and vertical neighbors
	assign d_sum = 10'(tm[0]) + 10'(tm[2]) + 10'(tm[6]) + 10'(tm[8]);
	assign d_cnt = 3'(in_frame[0]) + 3'(in_frame[2]) + 3'(in_frame[6]) + 3'(in_frame[8]);
	assign h_sum = 10'(tm[3]) + 10'(tm[5]);
	assign h_cnt = 3'(in_frame[3]) + 3'(in_frame[5]);
	assign v_sum = 10'(tm[1]) + 10'(tm[7]);
	assign v_cnt = 3'(in_frame[1]) + 3'(in_frame[7]);
	assign o_sum = h_sum + v_sum;
	assign o_cnt = h_cnt + v_cnt;

	always_comb begin
		priority if (!job.py_odd && !job.px_odd) begin
			own = OWN_RED;
		end else if (job.py_odd && job.px_odd) begin
			own = OWN_BLUE;
		end else if (!job.py_odd) begin
			own = OWN_GREEN_R;
		end else begin
			own = OWN_GREEN_B;
		end
	end

	always_comb begin
		num_g = o_sum;
		cnt_g = o_cnt;
		unique case (own)
			OWN_RED: begin
				num_r = d_sum; cnt_r = d_cnt;
				num_b = d_sum; cnt_b = d_cnt;
			end
			OWN_BLUE: begin
				num_r = d_sum; cnt_r = d_cnt;
				num_b = d_sum; cnt_b = d_cnt;
			end
			OWN_GREEN_R: begin
				num_r = h_sum; cnt_r = h_cnt;
				num_b = v_sum; cnt_b = v_cnt;
			end
			OWN_GREEN_B: begin
				num_r = v_sum; cnt_r = v_cnt;
				num_b = h_sum; cnt_b = h_cnt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (job_ready) begin
			valid_s3 <= job_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready) begin
			own_s3    <= own;
			centre_s3 <= job.nb[4];
			num_r_s3  <= num_r;
			cnt_r_s3  <= cnt_r;
			num_g_s3  <= num_g;
			cnt_g_s3  <= cnt_g;
			num_b_s3  <= num_b;
			cnt_b_s3  <= cnt_b;
			last_s3   <= job.last;
			fe_s3     <= job.frame_end;

			out_s4.red   <= (own_s3 == OWN_RED) ? centre_s3
				: bbd_pkg::div_mean(num_r_s3, cnt_r_s3);
			out_s4.green <= (own_s3 == OWN_GREEN_R || own_s3 == OWN_GREEN_B) ? centre_s3
				: bbd_pkg::div_mean(num_g_s3, cnt_g_s3);
			out_s4.blue  <= (own_s3 == OWN_BLUE) ? centre_s3
				: bbd_pkg::div_mean(num_b_s3, cnt_b_s3);
			out_s4.last_of_run <= last_s3;
			out_s4.frame_end   <= fe_s3;
		end
	end

	assign pix_out.valid = valid_s4;
	assign pix_out.data  = out_s4;

endmodule

/* sv/bayer_bilinear_demosaic.sv */
// Bayer RGGB bilinear demosaic, one raw sample in and one RGB pixel out per cycle while pix_out does not stall.
// Order: pixel (x, y) passes the sample register, the item queue, the job register and the interpolator stages
// after sample (x+1, y+1) is transferred; further pixels released by the same sample follow it.
// Throughput: one sample per cycle while pix_out does not stall, set by the line-store loop and the interpolator;
// samples that release several pixels (last column, last row) can hold pix_in.ready low once the item queue fills.
// Reset: position counters and window cleared, size 160x120; line stores are not cleared.
module bayer_bilinear_demosaic #(
	parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bbd_stream_if.sink   pix_in,
	bbd_stream_if.source pix_out,
	bbd_stream_if.sink   cfg
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WCW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;

	// configuration
	logic [8:0]  img_w_q;
	logic [11:0] img_h_q;
	logic [WCW-1:0] w_eff;
	logic [11:0]    h_eff;

	// position counters
	logic [AW-1:0] col_q, col0, col_cur;
	logic [11:0]   row_q, row0, row_tmp, row_cur;
	logic          col_wrap, col_last, row_last, accept;
	logic [3:0]    flags;

	// window stage
	logic          valid_s1, fwd_s1, col_odd_s1, row_odd_s1, col_ge2_s1, row_ge2_s1;
	logic [7:0]    sample_s1;
	logic [AW-1:0] addr_s1;
	logic [3:0]    flags_s1;
	logic [15:0]   ram_rdata, rd_word, wr_word, fwd_data_q;
	logic [8:0][7:0] win_q, win_nx;

	// item queue
	bbd_pkg::bbd_item_t fifo_q [bbd_pkg::FIFO_DEPTH];
	logic [bbd_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [bbd_pkg::FIFO_CW-1:0] fifo_cnt_q;
	logic               push, pop;
	bbd_pkg::bbd_item_t head;

	// serializer
	logic [3:0] done_q, pend;
	logic [1:0] idx;
	logic       ser_last, issue, job_ready, job_valid_s2;
	bbd_pkg::bbd_job_t job_nx, job_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= bbd_pkg::IMG_W_RESET;
			img_h_q <= bbd_pkg::IMG_H_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				bbd_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg.data.wdata[8:0];
				bbd_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg.data.wdata[11:0];
			endcase
		end
	end

	always_comb begin
		priority if (img_w_q < bbd_pkg::WIDTH_MIN) begin
			w_eff = WCW'(bbd_pkg::WIDTH_MIN);
		end else if (WCW'(img_w_q) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(img_w_q);
		end
	end

	assign h_eff = (img_h_q < bbd_pkg::HEIGHT_MIN) ? bbd_pkg::HEIGHT_MIN : img_h_q;

	// ---- position of the incoming sample ----
	assign pix_in.ready = (fifo_cnt_q + bbd_pkg::FIFO_CW'(valid_s1))
		< bbd_pkg::FIFO_CW'(bbd_pkg::FIFO_DEPTH);
	assign accept = pix_in.valid && pix_in.ready;

	assign col0     = pix_in.data.frame_start ? '0 : col_q;
	assign row0     = pix_in.data.frame_start ? '0 : row_q;
	assign col_wrap = WCW'(col0) >= w_eff;
	assign col_cur  = col_wrap ? '0 : col0;
	assign row_tmp  = col_wrap ? row0 + 12'd1 : row0;
	assign row_cur  = (row_tmp >= h_eff) ? '0 : row_tmp;
	assign col_last = WCW'(col_cur) == w_eff - WCW'(1);
	assign row_last = row_cur == h_eff - 12'd1;

	assign flags[0] = (row_cur != '0) && (col_cur != '0);
	assign flags[1] = (row_cur != '0) && col_last;
	assign flags[2] = row_last && (col_cur != '0);
	assign flags[3] = row_last && col_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_cur + 12'd1;
			end else begin
				col_q <= col_cur + AW'(1);
				row_q <= row_cur;
			end
		end
	end

	// ---- line stores: {older, newer} per column ----
	bbd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (wr_word),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1  <= pix_in.data.raw_sample;
			addr_s1    <= col_cur;
			fwd_s1     <= valid_s1 && (addr_s1 == col_cur);
			col_odd_s1 <= col_cur[0];
			row_odd_s1 <= row_cur[0];
			col_ge2_s1 <= col_cur > AW'(1);
			row_ge2_s1 <= row_cur > 12'd1;
			flags_s1   <= flags;
		end
		if (valid_s1) begin
			fwd_data_q <= wr_word;
		end
	end

	// take the word being written last cycle when the read hit the same column
	assign rd_word = fwd_s1 ? fwd_data_q : ram_rdata;
	assign wr_word = {rd_word[7:0], sample_s1};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nx[4'(k*3)]   = win_q[4'(k*3+1)];
			win_nx[4'(k*3+1)] = win_q[4'(k*3+2)];
		end
		win_nx[2] = rd_word[15:8];
		win_nx[5] = rd_word[7:0];
		win_nx[8] = sample_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_nx;
		end
	end

	// ---- item queue; samples that release no pixel are dropped ----
	assign push = valid_s1 && (flags_s1 != '0);
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{win: win_nx, col_odd: col_odd_s1, row_odd: row_odd_s1,
				col_ge2: col_ge2_s1, row_ge2: row_ge2_s1, flags: flags_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bbd_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bbd_pkg::FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + bbd_pkg::FIFO_CW'(push) - bbd_pkg::FIFO_CW'(pop);
		end
	end

	// ---- serializer: one pixel per cycle from the head item while the interpolator is ready ----
	assign pend  = head.flags & ~done_q;
	assign issue = (fifo_cnt_q != '0) && job_ready;

	always_comb begin
		priority if (pend[0]) begin
			idx = 2'd0;
		end else if (pend[1]) begin
			idx = 2'd1;
		end else if (pend[2]) begin
			idx = 2'd2;
		end else begin
			idx = 2'd3;
		end
	end

	assign ser_last = (pend & ~(4'b0001 << idx)) == '0;
	assign pop      = issue && ser_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (issue) begin
			done_q <= ser_last ? '0 : (done_q | (4'b0001 << idx));
		end
	end

	// idx[0]: pixel is the right column; idx[1]: pixel is the bottom row
	always_comb begin
		int wr, wc;
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				wr = j + int'(idx[1]);
				wc = k + int'(idx[0]);
				job_nx.nb[4'(j*3+k)] = (wr <= 2 && wc <= 2) ? head.win[4'(wr*3+wc)] : '0;
			end
		end
		job_nx.left_ok   = idx[0] || head.col_ge2;
		job_nx.right_ok  = !idx[0];
		job_nx.top_ok    = idx[1] || head.row_ge2;
		job_nx.bottom_ok = !idx[1];
		job_nx.px_odd    = idx[0] ? head.col_odd : !head.col_odd;
		job_nx.py_odd    = idx[1] ? head.row_odd : !head.row_odd;
		job_nx.last      = ser_last;
		job_nx.frame_end = idx[0] && idx[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s2 <= 1'b0;
		end else if (job_ready) begin
			job_valid_s2 <= fifo_cnt_q != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready) begin
			job_s2 <= job_nx;
		end
	end

	bbd_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid_s2),
		.job       (job_s2),
		.job_ready (job_ready),
		.pix_out   (pix_out)
	);

`ifndef SYNTHESIS
	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (fifo_cnt_q < bbd_pkg::FIFO_CW'(bbd_pkg::FIFO_DEPTH)))
		else $error("item queue overflow");

	a_fifo_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (fifo_cnt_q != '0))
		else $error("item queue underflow");

	a_head_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_cnt_q != '0) |-> (head.flags != '0))
		else $error("queued item releases no pixel");

	a_fwd_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> $past(valid_s1))
		else $error("forwarding without a preceding line-store write");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.data.frame_end) |-> pix_out.data.last_of_run)
		else $error("frame end pixel not last of its run");
`endif

endmodule
